>>> sv/prs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_pkg
// Shared constants, codes and control types of the Poisson relaxation sweep.
// ----------------------------------------------------------------------------
package prs_pkg;

  localparam int DefGridSide  = 64;
  localparam int DefValueBits = 32;
  localparam int SumBits      = 44;
  localparam int MaxBits      = 32;
  localparam int WeightBits   = 16;
  localparam int UnitWeight   = 16384;

  // item function codes
  localparam logic [1:0] FuncWriteSol = 2'd0;
  localparam logic [1:0] FuncWriteSrc = 2'd1;
  localparam logic [1:0] FuncSweep    = 2'd2;
  localparam logic [1:0] FuncRead     = 2'd3;

  // solver modes
  localparam logic [1:0] ModeJacobi = 2'd0;
  localparam logic [1:0] ModeJor    = 2'd1;
  localparam logic [1:0] ModeSor    = 2'd2;
  localparam logic [1:0] ModeUnused = 2'd3;

  // register indexes
  localparam logic [1:0] CfgSolverMode   = 2'd0;
  localparam logic [1:0] CfgRelaxFactor  = 2'd1;
  localparam logic [1:0] CfgInteriorSize = 2'd2;

  // stage enables of the cell update datapath
  typedef struct packed {
    logic mul1;
    logic mul2;
    logic fin;
  } upd_ctrl_t;

endpackage

>>> sv/prs_sol_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_sol_mem
// Solution store: both banks side by side in one word, per-bank write lanes,
// two registered read ports.
// ----------------------------------------------------------------------------
module prs_sol_mem #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic [1:0]               we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [2*WIDTH-1:0]       wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [2*WIDTH-1:0]       rdata0,
  output logic [2*WIDTH-1:0]       rdata1
);

  logic [2*WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we[0]) begin
      mem[waddr][WIDTH-1:0] <= wdata[WIDTH-1:0];
    end
    if (we[1]) begin
      mem[waddr][2*WIDTH-1:WIDTH] <= wdata[2*WIDTH-1:WIDTH];
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

>>> sv/prs_src_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_src_mem
// Source grid store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module prs_src_mem #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/prs_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_update
// Cell update datapath: neighbor sum and weighted old value, weighted sum,
// then rounding, wrap and absolute change.
// ----------------------------------------------------------------------------
module prs_update #(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  prs_pkg::upd_ctrl_t           ctrl,
  input  logic [prs_pkg::WeightBits-1:0] weight,
  input  logic signed [VALUE_BITS-1:0] u,
  input  logic signed [VALUE_BITS-1:0] up,
  input  logic signed [VALUE_BITS-1:0] left,
  input  logic signed [VALUE_BITS-1:0] down,
  input  logic signed [VALUE_BITS-1:0] right,
  input  logic signed [VALUE_BITS-1:0] src,
  output logic signed [VALUE_BITS-1:0] res,
  output logic [VALUE_BITS:0]          absd
);

  import prs_pkg::*;

  localparam int V   = VALUE_BITS;
  localparam int GW  = V + 3;
  localparam int PW1 = V + 17;
  localparam int PW2 = V + 20;
  localparam int NW  = V + 21;

  logic signed [16:0]    wt;
  logic signed [16:0]    cw;
  logic signed [GW-1:0]  g_sum;
  logic signed [GW-1:0]  g;
  logic signed [PW1-1:0] p1;
  logic signed [PW2-1:0] p2;
  logic signed [NW-1:0]  num;
  logic signed [V-1:0]   res_c;
  logic signed [V:0]     d;

  assign wt    = signed'({1'b0, weight});
  assign cw    = 17'(UnitWeight) - wt;
  assign g_sum = GW'(up) + GW'(left) + GW'(down) + GW'(right) - GW'(src);
  // +0.5 then floor: round half up
  assign num   = (NW'(p1) <<< 2) + NW'(p2) + NW'(32768);
  assign res_c = num[V+15:16];
  assign d     = {res_c[V-1], res_c} - {u[V-1], u};

  always_ff @(posedge clk) begin
    if (ctrl.mul1) begin
      g  <= g_sum;
      p1 <= PW1'(cw) * PW1'(u);
    end
    if (ctrl.mul2) begin
      p2 <= PW2'(wt) * PW2'(g);
    end
    if (ctrl.fin) begin
      res  <= res_c;
      absd <= d[V] ? unsigned'(-d) : unsigned'(d);
    end
  end

endmodule

>>> sv/poisson_relaxation_sweep.sv
`timescale 1ns / 1ps
// Sequence: a cell write goes through S_DONE, a cell read through S_RDWAIT and
// S_DONE, a sweep through S_ROW per interior row, S_NBR to S_ACC per cell, then
// S_SWEND and S_DONE; S_DONE loads the output register. Throughput: one item at
// a time; the per-cell steps are set by the serial neighbor fetch on the solution
// memory ports and two chained multiplies. Reset: synchronous, clears control,
// config to defaults, bank A current. Grid memories are not cleared and hold unknown data until written.
// ----------------------------------------------------------------------------
// poisson_relaxation_sweep
// Five-point Jacobi / JOR / SOR relaxation over a grid held in memory.
// ----------------------------------------------------------------------------
module poisson_relaxation_sweep #(
  parameter int GRID_SIDE  = prs_pkg::DefGridSide,
  parameter int VALUE_BITS = prs_pkg::DefValueBits
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    func,
  input  logic [5:0]                    row,
  input  logic [5:0]                    col,
  input  logic signed [31:0]            cell_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            read_value,
  output logic [prs_pkg::SumBits-1:0]   change_sum,
  output logic [prs_pkg::MaxBits-1:0]   change_max,
  input  logic                          cfg_wr_en,
  input  logic [1:0]                    cfg_index,
  input  logic [prs_pkg::WeightBits-1:0] cfg_data
);

  import prs_pkg::*;

  localparam int V         = VALUE_BITS;
  localparam int CellCount = GRID_SIDE * GRID_SIDE;
  localparam int AW        = $clog2(CellCount);
  localparam int IW        = $clog2(GRID_SIDE);
  localparam int AccW      = ((SumBits > V + 1) ? SumBits : V + 1) + 1;
  localparam logic [AW-1:0] RowStep = AW'(GRID_SIDE);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_RDWAIT = 11'b00000000010,
    S_DONE   = 11'b00000000100,
    S_ROW    = 11'b00000001000,
    S_NBR    = 11'b00000010000,
    S_UP     = 11'b00000100000,
    S_MUL1   = 11'b00001000000,
    S_MUL2   = 11'b00010000000,
    S_FIN    = 11'b00100000000,
    S_ACC    = 11'b01000000000,
    S_SWEND  = 11'b10000000000
  } state_t;

  state_t state;

  logic [1:0]            solver_mode;
  logic [WeightBits-1:0] relax_factor;
  logic [5:0]            interior_size;
  logic                  cur;
  logic [AW-1:0]         k;
  logic [IW-1:0]         ci;
  logic [IW-1:0]         cj;
  logic                  row_start;
  logic                  is_read;
  logic                  rd_ok;
  logic signed [V-1:0]   rd_hold;
  logic signed [V-1:0]   u_r, left_r, down_r, right_r, src_r;
  logic [SumBits-1:0]    sum, lat_sum;
  logic [MaxBits-1:0]    mx, lat_max;

  logic                  in_acc;
  logic                  in_grid;
  logic [AW-1:0]         in_addr;
  logic signed [V-1:0]   cv;
  logic [IW-1:0]         n_eff;
  logic                  sor;
  logic [WeightBits-1:0] weight;

  logic [1:0]            sol_we;
  logic [AW-1:0]         sol_waddr, r0, r1;
  logic [2*V-1:0]        sol_wdata, rd0, rd1;
  logic                  src_we;
  logic [V-1:0]          src_rd;
  logic signed [V-1:0]   rd0_old, rd0_new, rd1_old, up_val;

  upd_ctrl_t             uctrl;
  logic signed [V-1:0]   res;
  logic [V:0]            absd;
  logic [AccW-1:0]       acc;
  logic [SumBits-1:0]    sum_next;
  logic [63:0]           absd64;
  logic [MaxBits-1:0]    dcl;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && (state == S_IDLE);
  assign in_grid  = ({3'b0, row} < 9'(GRID_SIDE)) && ({3'b0, col} < 9'(GRID_SIDE));
  assign in_addr  = AW'(int'(row) * GRID_SIDE + int'(col));
  assign cv       = V'(cell_value);
  assign n_eff    = (int'(interior_size) > GRID_SIDE - 2) ? IW'(GRID_SIDE - 2)
                                                          : IW'(interior_size);
  assign sor      = solver_mode[1];
  assign weight   = (solver_mode == ModeJacobi) ? WeightBits'(UnitWeight) : relax_factor;

  // bank A in the low lane, bank B in the high lane
  assign rd0_old = cur ? rd0[2*V-1:V] : rd0[V-1:0];
  assign rd0_new = cur ? rd0[V-1:0]   : rd0[2*V-1:V];
  assign rd1_old = cur ? rd1[2*V-1:V] : rd1[V-1:0];
  assign up_val  = sor ? rd0_new : rd0_old;

  always_comb begin
    sol_we    = 2'b00;
    sol_waddr = k;
    sol_wdata = {res, res};
    r0        = k;
    r1        = k;
    src_we    = 1'b0;
    case (state)
      S_IDLE: begin
        sol_waddr = in_addr;
        sol_wdata = {cv, cv};
        r0        = in_addr;
        if (in_acc && in_grid && func == FuncWriteSol) begin
          sol_we = 2'b11;
        end
        if (in_acc && in_grid && func == FuncWriteSrc) begin
          src_we = 1'b1;
        end
      end
      S_ROW: begin
        r1 = k - AW'(1);
      end
      S_NBR: begin
        r0 = k + RowStep;
        r1 = k + AW'(1);
      end
      S_UP: begin
        r0 = k - RowStep;
      end
      S_ACC: begin
        sol_we = cur ? 2'b01 : 2'b10;
      end
      default: ;
    endcase
  end

  assign uctrl.mul1 = (state == S_MUL1);
  assign uctrl.mul2 = (state == S_MUL2);
  assign uctrl.fin  = (state == S_FIN);

  assign acc      = AccW'(sum) + AccW'(absd);
  assign sum_next = (acc > AccW'({SumBits{1'b1}})) ? {SumBits{1'b1}} : acc[SumBits-1:0];
  assign absd64   = 64'(absd);
  assign dcl      = (absd64 > 64'({MaxBits{1'b1}})) ? {MaxBits{1'b1}} : absd64[MaxBits-1:0];

  prs_sol_mem #(.DEPTH(CellCount), .WIDTH(V)) u_sol_mem (
    .clk    (clk),
    .we     (sol_we),
    .waddr  (sol_waddr),
    .wdata  (sol_wdata),
    .raddr0 (r0),
    .raddr1 (r1),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  prs_src_mem #(.DEPTH(CellCount), .WIDTH(V)) u_src_mem (
    .clk   (clk),
    .we    (src_we),
    .waddr (in_addr),
    .wdata (cv),
    .raddr (k),
    .rdata (src_rd)
  );

  prs_update #(.VALUE_BITS(V)) u_update (
    .clk    (clk),
    .ctrl   (uctrl),
    .weight (weight),
    .u      (u_r),
    .up     (up_val),
    .left   (left_r),
    .down   (down_r),
    .right  (right_r),
    .src    (src_r),
    .res    (res),
    .absd   (absd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      solver_mode   <= ModeJor;
      relax_factor  <= WeightBits'(8192);
      interior_size <= 6'd62;
      cur           <= 1'b0;
      lat_sum       <= '0;
      lat_max       <= '0;
      out_valid     <= 1'b0;
      row_start     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CfgSolverMode:   solver_mode   <= cfg_data[1:0];
          CfgRelaxFactor:  relax_factor  <= cfg_data;
          CfgInteriorSize: interior_size <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            is_read <= (func == FuncRead);
            rd_hold <= '0;
            rd_ok   <= in_grid;
            case (func)
              FuncSweep: begin
                ci    <= IW'(1);
                cj    <= IW'(1);
                k     <= RowStep + AW'(1);
                sum   <= '0;
                mx    <= '0;
                state <= (n_eff == '0) ? S_SWEND : S_ROW;
              end
              FuncRead: state <= S_RDWAIT;
              default:  state <= S_DONE;
            endcase
          end
        end
        S_RDWAIT: begin
          rd_hold <= rd_ok ? rd0_old : '0;
          state   <= S_DONE;
        end
        S_ROW: begin
          row_start <= 1'b1;
          state     <= S_NBR;
        end
        S_NBR: begin
          // first cell of a row: center and left come from the row fetch
          if (row_start) begin
            u_r    <= rd0_old;
            left_r <= rd1_old;
          end
          row_start <= 1'b0;
          state     <= S_UP;
        end
        S_UP: begin
          down_r  <= rd0_old;
          right_r <= rd1_old;
          src_r   <= src_rd;
          state   <= S_MUL1;
        end
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_FIN;
        S_FIN:  state <= S_ACC;
        S_ACC: begin
          sum <= sum_next;
          mx  <= (dcl > mx) ? dcl : mx;
          if (cj == n_eff) begin
            if (ci == n_eff) begin
              state <= S_SWEND;
            end else begin
              ci    <= ci + IW'(1);
              cj    <= IW'(1);
              k     <= k + RowStep + AW'(1) - AW'(n_eff);
              state <= S_ROW;
            end
          end else begin
            // slide the window one column right
            cj     <= cj + IW'(1);
            k      <= k + AW'(1);
            u_r    <= right_r;
            left_r <= sor ? res : u_r;
            state  <= S_NBR;
          end
        end
        S_SWEND: begin
          lat_sum <= sum;
          lat_max <= mx;
          cur     <= ~cur;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            read_value <= is_read ? 32'(rd_hold) : '0;
            change_sum <= lat_sum;
            change_max <= lat_max;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_swap: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEND) |=> (cur != $past(cur)))
    else $error("bank select did not toggle at sweep end");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_NBR) |-> (cj != '0) && (cj <= n_eff) && (ci != '0) && (ci <= n_eff))
    else $error("sweep left the interior");

  a_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && (!out_valid || !out_stall) |=> out_valid && (state == S_IDLE))
    else $error("result not posted");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    (sol_we == 2'b11) |-> in_acc)
    else $error("dual bank write outside an accepted write");
`endif

endmodule

>>> test/poisson_relaxation_sweep_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poisson_relaxation_sweep_test
// Drives cell writes, reads and relaxation sweeps into the relaxation engine
// and checks every result beat against a bit-level software grid kept here.
// ----------------------------------------------------------------------------
module poisson_relaxation_sweep_test;
  import prs_pkg::*;

  localparam int Side = 64;
  localparam int Cells = Side * Side;
  localparam longint SumCap = (64'd1 << 44) - 1;
  localparam int WatchLimit = 200000;

  typedef struct packed {
    logic signed [31:0] rd;
    logic [43:0] sum;
    logic [31:0] mx;
  } result_t;

  class relax_board;
    logic signed [31:0] grid_a [Cells];
    logic signed [31:0] grid_b [Cells];
    logic signed [31:0] src [Cells];
    bit cur;
    logic [1:0] mode;
    logic [15:0] weight;
    logic [5:0] span;
    logic [43:0] last_sum;
    logic [31:0] last_max;
    result_t pending [$];
    int errors;
    int results;

    function new();
      cur = 0; mode = ModeJor; weight = 16'd8192; span = 6'd62;
      last_sum = 0; last_max = 0; errors = 0; results = 0;
      for (int k = 0; k < Cells; k++) begin
        grid_a[k] = 0; grid_b[k] = 0; src[k] = 0;
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      if (idx == CfgSolverMode) mode = val[1:0];
      else if (idx == CfgRelaxFactor) weight = val;
      else if (idx == CfgInteriorSize) span = val[5:0];
    endfunction

    function logic signed [31:0] rdcell(bit b, int k);
      return b ? grid_b[k] : grid_a[k];
    endfunction

    function void relax();
      longint w, u, g, num, d, s, m;
      logic signed [31:0] nv;
      int n, k;
      bit sor;
      bit nb;
      w = (mode == ModeJacobi) ? UnitWeight : weight;
      sor = mode >= ModeSor;
      n = (span > Side - 2) ? Side - 2 : span;
      nb = !cur;
      s = 0; m = 0;
      for (int i = 1; i <= n; i++)
        for (int j = 1; j <= n; j++) begin
          k = i * Side + j;
          u = rdcell(cur, k);
          g = longint'(rdcell(sor ? nb : cur, k - Side)) + rdcell(sor ? nb : cur, k - 1)
              + rdcell(cur, k + Side) + rdcell(cur, k + 1) - src[k];
          num = (UnitWeight - w) * (u <<< 2) + w * g + 32768;
          nv = 32'(num >>> 16);
          d = longint'(nv) - u;
          if (d < 0) d = -d;
          s += d;
          if (s > SumCap) s = SumCap;
          if (d > m) m = d;
          if (nb) grid_b[k] = nv; else grid_a[k] = nv;
        end
      last_sum = s[43:0]; last_max = m[31:0];
      cur = !cur;
    endfunction

    function void note_item(logic [1:0] f, logic [5:0] r, logic [5:0] c,
                            logic signed [31:0] v);
      result_t e;
      int k;
      k = r * Side + c;
      e.rd = 0;
      case (f)
        FuncWriteSol: begin grid_a[k] = v; grid_b[k] = v; end
        FuncWriteSrc: src[k] = v;
        FuncSweep: relax();
        default: e.rd = rdcell(cur, k);
      endcase
      e.sum = last_sum; e.mx = last_max;
      pending.push_back(e);
    endfunction

    function void check_beat(result_t a);
      result_t e;
      results++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.rd !== a.rd) begin
        $display("%0t: read_value exp %h got %h", $time, e.rd, a.rd); errors++;
      end
      if (e.sum !== a.sum) begin
        $display("%0t: change_sum exp %h got %h", $time, e.sum, a.sum); errors++;
      end
      if (e.mx !== a.mx) begin
        $display("%0t: change_max exp %h got %h", $time, e.mx, a.mx); errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall, cfg_wr_en;
  logic [1:0] func, cfg_index;
  logic [5:0] row, col;
  logic signed [31:0] cell_value, read_value;
  logic [43:0] change_sum;
  logic [31:0] change_max;
  logic [15:0] cfg_data;

  relax_board board;
  int send_idle, recv_idle, sweeps;
  int quiet = 0;

  poisson_relaxation_sweep dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) board.note_item(func, row, col, cell_value);
      if (out_valid && !out_stall) board.check_beat({read_value, change_sum, change_max});
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= WatchLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle);

  // valid stays high into the next beat; settle drops it at the end of a burst
  task automatic send(logic [1:0] f, logic [5:0] r, logic [5:0] c, logic [31:0] v);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1; func <= f; row <= r; col <= c; cell_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_wr_en <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 0;
    board.set_reg(idx, val);
    @(negedge clk);
  endtask

  // fill every cell of an (n+2) square so sweeps and reads see written data
  task automatic fill_grid(int n);
    for (int i = 0; i <= n + 1; i++)
      for (int j = 0; j <= n + 1; j++) begin
        send(FuncWriteSol, 6'(i), 6'(j), $urandom());
        send(FuncWriteSrc, 6'(i), 6'(j),
             $urandom_range(1, 0) ? $urandom() : $urandom_range(65535));
      end
  endtask

  task automatic random_items(int count, int n);
    int pick;
    for (int t = 0; t < count; t++) begin
      pick = $urandom_range(9);
      if (pick < 3)
        send(FuncRead, 6'($urandom_range(n + 1)), 6'($urandom_range(n + 1)), $urandom());
      else if (pick < 5) begin
        send(FuncSweep, 6'($urandom()), 6'($urandom()), $urandom());
        sweeps++;
      end
      else if (pick < 7)
        send(FuncWriteSol, 6'($urandom_range(n + 1)), 6'($urandom_range(n + 1)), $urandom());
      else if (pick < 9)
        send(FuncWriteSrc, 6'($urandom_range(n + 1)), 6'($urandom_range(n + 1)), $urandom());
      else
        send(2'($urandom_range(1)), 6'($urandom_range(63)), 6'($urandom_range(63)),
             $urandom());
    end
  endtask

  initial begin
    int n;
    board = new();
    rst = 1; in_valid = 0; func = 0; row = 0; col = 0; cell_value = 0;
    cfg_wr_en = 0; cfg_index = 0; cfg_data = 0;
    send_idle = 0; recv_idle = 0; sweeps = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: small grid, extremes, every mode, weight extremes, empty interior
    write_reg(CfgInteriorSize, 16'd2);
    send(FuncWriteSol, 0, 0, 32'h7fffffff);
    send(FuncRead, 0, 0, 0);
    send(FuncWriteSol, 63, 63, 32'h80000000);
    send(FuncRead, 63, 63, 32'hffffffff);
    fill_grid(2);
    send(FuncSweep, 0, 0, 0);
    send(FuncRead, 1, 1, 0);
    settle();
    write_reg(CfgSolverMode, 16'(ModeJacobi));
    send(FuncSweep, 63, 63, 0);
    settle();
    write_reg(CfgSolverMode, 16'(ModeSor));
    write_reg(CfgRelaxFactor, 16'd32768);
    send(FuncSweep, 0, 0, 0);
    send(FuncRead, 2, 2, 0);
    settle();
    write_reg(CfgSolverMode, 16'(ModeUnused));
    write_reg(CfgRelaxFactor, 16'hffff);
    send(FuncSweep, 0, 0, 0);
    settle();
    write_reg(CfgRelaxFactor, 16'd0);
    send(FuncSweep, 0, 0, 0);
    settle();
    write_reg(CfgInteriorSize, 16'd0);
    send(FuncSweep, 0, 0, 0);
    settle();
    sweeps = 6;

    // the filled 4x4 corner covers every cell touched with an interior of 1 or 2
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? (ph == 3 ? 26 : 51) : 0;
      recv_idle = (ph == 2 || ph == 3) ? (ph == 3 ? 26 : 51) : 0;
      n = $urandom_range(1, 2);
      write_reg(CfgInteriorSize, 16'(n));
      write_reg(CfgSolverMode, 16'($urandom_range(3)));
      write_reg(CfgRelaxFactor, $urandom_range(1) ? 16'($urandom_range(32768))
                                                  : 16'($urandom()));
      random_items(24, n);
      settle();
    end
    repeat (20) @(negedge clk);

    $display("Ran %0d sweeps and %0d result beats over Jacobi, JOR and SOR settings.",
             sweeps, board.results);
    $display("Covered weight extremes, empty and small interiors, and random stalls.");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
